>>> rtl/nfca_pkg.sv
// Package for the next-fit chunk allocator.
// Holds header and result types, opcodes, header states, status codes and sizes.
// No dependencies.
package nfca_pkg;

  localparam int POOL_CHUNKS_DEF = 65536;

  localparam int SIZE_W  = 16;
  localparam int STATE_W = 3;
  localparam int OPC_W   = 3;
  localparam int BYTES_W = 22;
  localparam int OFS_W   = 23;
  localparam int STAT_W  = 2;
  localparam int NEED_W  = 17;

  localparam int FIRST_USER_OFS = 16448;  // first block offset plus one chunk
  localparam int CHUNK_SHIFT    = 6;
  localparam int CHUNK_BYTES    = 64;
  localparam int SPLIT_MIN      = 2;
  localparam int POOL_CFG_RESET = 65535;

  localparam logic [OPC_W-1:0] OP_FORMAT   = 3'd0;
  localparam logic [OPC_W-1:0] OP_RESERVE  = 3'd1;
  localparam logic [OPC_W-1:0] OP_ACTIVATE = 3'd2;
  localparam logic [OPC_W-1:0] OP_FREE     = 3'd3;
  localparam logic [OPC_W-1:0] OP_RECOVER  = 3'd4;

  localparam logic [STATE_W-1:0] ST_FREE       = 3'd0;
  localparam logic [STATE_W-1:0] ST_RESERVED   = 3'd1;
  localparam logic [STATE_W-1:0] ST_ACTIVATING = 3'd2;
  localparam logic [STATE_W-1:0] ST_ACTIVE     = 3'd3;
  localparam logic [STATE_W-1:0] ST_FREEING    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IGN = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [STATE_W-1:0] state;
  } hdr_t;

  localparam int HDR_W = SIZE_W + STATE_W;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFS_W-1:0]  goff;
    logic [SIZE_W-1:0] gchunks;
  } result_t;

  typedef enum logic [3:0] {
    CS_IDLE, CS_RD, CS_EV, CS_WEND, CS_FMT0, CS_FMT1,
    CS_SPLIT, CS_HITW, CS_OFS, CS_OFEV, CS_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_FIND1, PH_FIND2, PH_MERGE, PH_RECOV
  } phase_t;

endpackage

>>> rtl/nfca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nfca_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/nfca_alu.sv
// Shared index adder: header walk step and split position, with pool bound check.
// No dependencies.
module nfca_alu #(
  parameter int W     = 17,
  parameter int LIMIT = 65536
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] sum,
  output logic         in_range
);

  localparam logic [W-1:0] LIM = W'(LIMIT);

  assign sum      = a + b;
  assign in_range = (sum < LIM);

endmodule

>>> rtl/nfca_ctrl.sv
// Sequencer for the allocator: header walks, merge, split, format, state checks.
// Depends on nfca_pkg, nfca_ram and nfca_alu.
module nfca_ctrl #(
  parameter int POOL_CHUNKS = nfca_pkg::POOL_CHUNKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nfca_pkg::OPC_W-1:0]    in_opcode,
  input  logic [nfca_pkg::BYTES_W-1:0]  in_request_bytes,
  input  logic [nfca_pkg::OFS_W-1:0]    in_block_offset,
  input  logic [nfca_pkg::SIZE_W-1:0]   pool_chunks,
  input  logic                          res_free,
  output logic                          res_valid,
  output nfca_pkg::result_t             res
);

  localparam int IDX_W  = $clog2(POOL_CHUNKS);
  localparam int WALK_W = ((IDX_W > nfca_pkg::SIZE_W) ? IDX_W : nfca_pkg::SIZE_W) + 1;
  localparam logic [WALK_W-1:0] POOL_LIM  = WALK_W'(POOL_CHUNKS);
  localparam logic [WALK_W-1:0] POOL_LAST = WALK_W'(POOL_CHUNKS - 1);

  nfca_pkg::ctrl_state_t state_r, state_nxt;
  nfca_pkg::phase_t      phase_r, phase_nxt;
  logic [nfca_pkg::OPC_W-1:0]  op_r, op_nxt;
  logic [nfca_pkg::NEED_W-1:0] need_r, need_nxt;
  logic [nfca_pkg::OFS_W-1:0]  ofs_r, ofs_nxt;
  logic [WALK_W-1:0]           walk_r, walk_nxt;
  logic [nfca_pkg::SIZE_W-1:0] rot_r, rot_nxt;
  logic                        hf_r, hf_nxt, hm_r, hm_nxt;
  logic [WALK_W-1:0]           first_r, first_nxt;
  logic [nfca_pkg::SIZE_W-1:0] sum_r, sum_nxt;
  logic [WALK_W-1:0]           hit_r, hit_nxt;
  logic [nfca_pkg::SIZE_W-1:0] hsz_r, hsz_nxt;
  nfca_pkg::result_t           res_r, res_nxt;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  nfca_pkg::hdr_t              ram_wdata, hdr;
  logic [nfca_pkg::HDR_W-1:0]  ram_rdata;

  logic [WALK_W-1:0]           alu_a, alu_b, alu_sum;
  logic                        alu_in_range;

  logic                        walk_ok, fit, finding;
  logic [nfca_pkg::NEED_W-1:0] sum_wide;
  logic [nfca_pkg::OFS_W-1:0]  ofs_sub;
  logic [WALK_W-1:0]           ofs_idx;
  logic                        ofs_bad;
  logic [WALK_W-1:0]           eff;
  logic [nfca_pkg::SIZE_W-1:0] left;
  logic [nfca_pkg::OFS_W:0]    bytes_up;
  logic [nfca_pkg::NEED_W-1:0] need_in;

  nfca_ram #(.WIDTH(nfca_pkg::HDR_W), .DEPTH(POOL_CHUNKS)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nfca_alu #(.W(WALK_W), .LIMIT(POOL_CHUNKS)) u_alu (
    .a        (alu_a),
    .b        (alu_b),
    .sum      (alu_sum),
    .in_range (alu_in_range)
  );

  assign hdr      = nfca_pkg::hdr_t'(ram_rdata);
  assign walk_ok  = (walk_r < POOL_LIM);
  assign finding  = (phase_r == nfca_pkg::PH_FIND1) || (phase_r == nfca_pkg::PH_FIND2);
  assign fit      = (need_r <= nfca_pkg::NEED_W'(hdr.size)) && (hdr.state == nfca_pkg::ST_FREE);
  assign sum_wide = nfca_pkg::NEED_W'(sum_r) + nfca_pkg::NEED_W'(hdr.size);
  assign left     = hsz_r - need_r[nfca_pkg::SIZE_W-1:0];

  // shared adder: split position in SPLIT, walk step elsewhere
  assign alu_a = (state_r == nfca_pkg::CS_SPLIT) ? hit_r : walk_r;
  assign alu_b = (state_r == nfca_pkg::CS_SPLIT) ? WALK_W'(need_r) : WALK_W'(hdr.size);

  assign ofs_sub = ofs_r - nfca_pkg::OFS_W'(nfca_pkg::FIRST_USER_OFS);
  assign ofs_idx = WALK_W'(ofs_sub[nfca_pkg::OFS_W-1:nfca_pkg::CHUNK_SHIFT]);
  assign ofs_bad = (ofs_r < nfca_pkg::OFS_W'(nfca_pkg::FIRST_USER_OFS)) ||
                   (ofs_r[nfca_pkg::CHUNK_SHIFT-1:0] != '0) || (ofs_idx >= POOL_LIM);

  always_comb begin
    if (pool_chunks < nfca_pkg::SIZE_W'(2)) begin
      eff = WALK_W'(2);
    end else if (WALK_W'(pool_chunks) > POOL_LAST) begin
      eff = POOL_LAST;
    end else begin
      eff = WALK_W'(pool_chunks);
    end
  end

  // chunks needed: header plus ceil(bytes/64), at least two
  assign bytes_up = (nfca_pkg::OFS_W + 1)'(in_request_bytes) +
                    (nfca_pkg::OFS_W + 1)'(nfca_pkg::CHUNK_BYTES - 1);
  assign need_in  = (in_request_bytes <= nfca_pkg::BYTES_W'(nfca_pkg::CHUNK_BYTES)) ?
                    nfca_pkg::NEED_W'(2) :
                    nfca_pkg::NEED_W'(bytes_up[nfca_pkg::OFS_W:nfca_pkg::CHUNK_SHIFT]) +
                    nfca_pkg::NEED_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nfca_pkg::CS_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            nfca_pkg::OP_FORMAT:                       state_nxt = nfca_pkg::CS_FMT0;
            nfca_pkg::OP_RESERVE, nfca_pkg::OP_RECOVER: state_nxt = nfca_pkg::CS_RD;
            nfca_pkg::OP_ACTIVATE, nfca_pkg::OP_FREE:   state_nxt = nfca_pkg::CS_OFS;
            default:                                    state_nxt = nfca_pkg::CS_DONE;
          endcase
        end
      end
      nfca_pkg::CS_RD:   state_nxt = walk_ok ? nfca_pkg::CS_EV : nfca_pkg::CS_WEND;
      nfca_pkg::CS_EV: begin
        if (hdr.size == '0) begin
          state_nxt = nfca_pkg::CS_WEND;
        end else if (finding && fit) begin
          state_nxt = nfca_pkg::CS_SPLIT;
        end else begin
          state_nxt = nfca_pkg::CS_RD;
        end
      end
      nfca_pkg::CS_WEND: begin
        unique case (phase_r)
          nfca_pkg::PH_FIND2: state_nxt = nfca_pkg::CS_DONE;
          nfca_pkg::PH_MERGE: state_nxt = (op_r == nfca_pkg::OP_RESERVE) ?
                                          nfca_pkg::CS_RD : nfca_pkg::CS_DONE;
          default:            state_nxt = nfca_pkg::CS_RD;
        endcase
      end
      nfca_pkg::CS_FMT0:  state_nxt = nfca_pkg::CS_FMT1;
      nfca_pkg::CS_FMT1:  state_nxt = nfca_pkg::CS_DONE;
      nfca_pkg::CS_SPLIT: state_nxt = nfca_pkg::CS_HITW;
      nfca_pkg::CS_HITW:  state_nxt = nfca_pkg::CS_DONE;
      nfca_pkg::CS_OFS: begin
        state_nxt = ((ofs_r == '0) || ofs_bad) ? nfca_pkg::CS_DONE : nfca_pkg::CS_OFEV;
      end
      nfca_pkg::CS_OFEV:  state_nxt = nfca_pkg::CS_DONE;
      nfca_pkg::CS_DONE:  state_nxt = res_free ? nfca_pkg::CS_IDLE : nfca_pkg::CS_DONE;
      default:            state_nxt = nfca_pkg::CS_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    need_nxt  = need_r;
    ofs_nxt   = ofs_r;
    walk_nxt  = walk_r;
    rot_nxt   = rot_r;
    hf_nxt    = hf_r;
    hm_nxt    = hm_r;
    first_nxt = first_r;
    sum_nxt   = sum_r;
    hit_nxt   = hit_r;
    hsz_nxt   = hsz_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = (state_r == nfca_pkg::CS_OFS) ? ofs_idx[IDX_W-1:0] : walk_r[IDX_W-1:0];
    in_ready  = (state_r == nfca_pkg::CS_IDLE);
    res_valid = (state_r == nfca_pkg::CS_DONE) && res_free;

    unique case (state_r)
      nfca_pkg::CS_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_opcode;
          need_nxt = need_in;
          ofs_nxt  = in_block_offset;
          res_nxt  = '{status: nfca_pkg::STAT_IGN, goff: '0, gchunks: '0};
          if (in_opcode == nfca_pkg::OP_RESERVE) begin
            phase_nxt = nfca_pkg::PH_FIND1;
            walk_nxt  = WALK_W'(rot_r);
          end else begin
            phase_nxt = nfca_pkg::PH_RECOV;
            walk_nxt  = '0;
          end
        end
      end
      nfca_pkg::CS_EV: begin
        if (hdr.size != '0) begin
          unique case (phase_r)
            nfca_pkg::PH_FIND1, nfca_pkg::PH_FIND2: begin
              if (fit) begin
                hit_nxt = walk_r;
                hsz_nxt = hdr.size;
              end else begin
                walk_nxt = alu_sum;
              end
            end
            nfca_pkg::PH_MERGE: begin
              walk_nxt = alu_sum;
              if (hdr.state == nfca_pkg::ST_FREE) begin
                if (!hf_r) begin
                  hf_nxt    = 1'b1;
                  first_nxt = walk_r;
                  sum_nxt   = hdr.size;
                end else begin
                  hm_nxt  = 1'b1;
                  sum_nxt = sum_wide[nfca_pkg::SIZE_W] ? '1 : sum_wide[nfca_pkg::SIZE_W-1:0];
                end
              end else begin
                if (hf_r && hm_r) begin
                  ram_we    = 1'b1;
                  ram_waddr = first_r[IDX_W-1:0];
                  ram_wdata = '{size: sum_r, state: nfca_pkg::ST_FREE};
                end
                hf_nxt  = 1'b0;
                hm_nxt  = 1'b0;
                sum_nxt = '0;
              end
            end
            default: begin
              walk_nxt  = alu_sum;
              ram_waddr = walk_r[IDX_W-1:0];
              ram_wdata = hdr;
              if ((hdr.state == nfca_pkg::ST_RESERVED) || (hdr.state == nfca_pkg::ST_FREEING)) begin
                ram_we          = 1'b1;
                ram_wdata.state = nfca_pkg::ST_FREE;
              end else if (hdr.state == nfca_pkg::ST_ACTIVATING) begin
                ram_we          = 1'b1;
                ram_wdata.state = nfca_pkg::ST_ACTIVE;
              end
            end
          endcase
        end
      end
      nfca_pkg::CS_WEND: begin
        unique case (phase_r)
          nfca_pkg::PH_FIND2: res_nxt.status = nfca_pkg::STAT_OOM;
          nfca_pkg::PH_MERGE: begin
            if (hf_r && hm_r) begin
              ram_we    = 1'b1;
              ram_waddr = first_r[IDX_W-1:0];
              ram_wdata = '{size: sum_r, state: nfca_pkg::ST_FREE};
            end
            rot_nxt = '0;
            if (op_r == nfca_pkg::OP_RESERVE) begin
              phase_nxt = nfca_pkg::PH_FIND2;
              walk_nxt  = '0;
            end else begin
              res_nxt.status = nfca_pkg::STAT_OK;
            end
          end
          default: begin
            phase_nxt = nfca_pkg::PH_MERGE;
            walk_nxt  = '0;
            hf_nxt    = 1'b0;
            hm_nxt    = 1'b0;
            sum_nxt   = '0;
          end
        endcase
      end
      nfca_pkg::CS_FMT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{size: eff[nfca_pkg::SIZE_W-1:0], state: nfca_pkg::ST_FREE};
      end
      nfca_pkg::CS_FMT1: begin
        ram_we         = 1'b1;
        ram_waddr      = eff[IDX_W-1:0];
        ram_wdata      = '{size: '0, state: nfca_pkg::ST_FREE};
        rot_nxt        = '0;
        res_nxt.status = nfca_pkg::STAT_OK;
      end
      nfca_pkg::CS_SPLIT: begin
        if (left >= nfca_pkg::SIZE_W'(nfca_pkg::SPLIT_MIN)) begin
          hsz_nxt = need_r[nfca_pkg::SIZE_W-1:0];
          if (alu_in_range) begin
            ram_we    = 1'b1;
            ram_waddr = alu_sum[IDX_W-1:0];
            ram_wdata = '{size: left, state: nfca_pkg::ST_FREE};
          end
        end
      end
      nfca_pkg::CS_HITW: begin
        ram_we    = 1'b1;
        ram_waddr = hit_r[IDX_W-1:0];
        ram_wdata = '{size: hsz_r, state: nfca_pkg::ST_RESERVED};
        rot_nxt   = hit_r[nfca_pkg::SIZE_W-1:0];
        res_nxt   = '{status: nfca_pkg::STAT_OK,
                      goff: nfca_pkg::OFS_W'({hit_r, {nfca_pkg::CHUNK_SHIFT{1'b0}}}) +
                            nfca_pkg::OFS_W'(nfca_pkg::FIRST_USER_OFS),
                      gchunks: hsz_r};
      end
      nfca_pkg::CS_OFS: begin
        if ((ofs_r != '0) && ofs_bad) begin
          res_nxt.status = nfca_pkg::STAT_BAD;
        end
      end
      nfca_pkg::CS_OFEV: begin
        ram_waddr = ofs_idx[IDX_W-1:0];
        ram_wdata = hdr;
        if (op_r == nfca_pkg::OP_ACTIVATE) begin
          if (hdr.state == nfca_pkg::ST_RESERVED) begin
            ram_we          = 1'b1;
            ram_wdata.state = nfca_pkg::ST_ACTIVE;
            res_nxt.status  = nfca_pkg::STAT_OK;
          end else begin
            res_nxt.status = nfca_pkg::STAT_BAD;
          end
        end else begin
          if ((hdr.state == nfca_pkg::ST_ACTIVE) || (hdr.state == nfca_pkg::ST_RESERVED)) begin
            ram_we          = 1'b1;
            ram_wdata.state = nfca_pkg::ST_FREE;
            res_nxt.status  = nfca_pkg::STAT_OK;
          end else if (hdr.state == nfca_pkg::ST_FREE) begin
            res_nxt.status = nfca_pkg::STAT_IGN;
          end else begin
            res_nxt.status = nfca_pkg::STAT_BAD;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nfca_pkg::CS_IDLE;
      phase_r <= nfca_pkg::PH_FIND1;
      rot_r   <= '0;
      hf_r    <= 1'b0;
      hm_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      rot_r   <= rot_nxt;
      hf_r    <= hf_nxt;
      hm_r    <= hm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    need_r  <= need_nxt;
    ofs_r   <= ofs_nxt;
    walk_r  <= walk_nxt;
    first_r <= first_nxt;
    sum_r   <= sum_nxt;
    hit_r   <= hit_nxt;
    hsz_r   <= hsz_nxt;
    res_r   <= res_nxt;
  end

endmodule

>>> rtl/next_fit_chunk_allocator_top.sv
// Reserve walks the headers from the rotate pointer; a miss adds a merge walk
// and a second search from the pool start. Recover walks twice. Format writes the
// first and end headers. Activate and free skip the header read on a null or bad offset.
// One item at a time: a new request is taken only after the last result is handed on.
// Synchronous active-low reset clears the sequencer, rotate pointer, output valid and
// sets pool_chunks to 65535; header RAM stays undefined until a format.
module next_fit_chunk_allocator_top #(
  parameter int POOL_CHUNKS = nfca_pkg::POOL_CHUNKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nfca_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nfca_pkg::OPC_W-1:0]    in_opcode,
  input  logic [nfca_pkg::BYTES_W-1:0]  in_request_bytes,
  input  logic [nfca_pkg::OFS_W-1:0]    in_block_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nfca_pkg::STAT_W-1:0]   out_status,
  output logic [nfca_pkg::OFS_W-1:0]    out_granted_offset,
  output logic [nfca_pkg::SIZE_W-1:0]   out_granted_chunks
);

  logic [nfca_pkg::SIZE_W-1:0] pool_r, pool_nxt;
  logic                        out_valid_r, out_valid_nxt;
  nfca_pkg::result_t           out_res_r, out_res_nxt;
  logic                        res_free, res_valid;
  nfca_pkg::result_t           res;

  assign res_free = !out_valid_r || out_ready;

  nfca_ctrl #(.POOL_CHUNKS(POOL_CHUNKS)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_request_bytes (in_request_bytes),
    .in_block_offset  (in_block_offset),
    .pool_chunks      (pool_r),
    .res_free         (res_free),
    .res_valid        (res_valid),
    .res              (res)
  );

  always_comb begin
    pool_nxt      = cfg_we ? cfg_wdata : pool_r;
    out_res_nxt   = res_valid ? res : out_res_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= nfca_pkg::SIZE_W'(nfca_pkg::POOL_CFG_RESET);
      out_valid_r <= 1'b0;
    end else begin
      pool_r      <= pool_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_granted_offset = out_res_r.goff;
  assign out_granted_chunks = out_res_r.gchunks;

endmodule

>>> rtl/nfca_checker.sv
// Port-level assertions for the allocator, bound to the top level.
// Depends on nfca_pkg and next_fit_chunk_allocator_top.
module nfca_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [nfca_pkg::STAT_W-1:0]   out_status,
  input logic [nfca_pkg::OFS_W-1:0]    out_granted_offset,
  input logic [nfca_pkg::SIZE_W-1:0]   out_granted_chunks
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != nfca_pkg::STAT_OK) |->
      (out_granted_offset == '0) && (out_granted_chunks == '0))
    else $error("grant fields set on a non-ok result");

  a_grant_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_granted_chunks != '0) |->
      out_granted_chunks >= nfca_pkg::SIZE_W'(nfca_pkg::SPLIT_MIN))
    else $error("grant smaller than two chunks");

  a_grant_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_granted_chunks != '0) |->
      (out_granted_offset[nfca_pkg::CHUNK_SHIFT-1:0] == '0))
    else $error("granted offset not chunk aligned");

endmodule

bind next_fit_chunk_allocator_top nfca_port_checker u_nfca_port_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_granted_offset (out_granted_offset),
  .out_granted_chunks (out_granted_chunks)
);
